@@ rtl/core/sdpsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdpsc_pkg
// Shared types and field widths for the step/direction position scan block.
// ----------------------------------------------------------------------------
package sdpsc_pkg;

  localparam int unsigned TargetBits   = 16;
  localparam int unsigned LimitBits    = 16;
  localparam int unsigned PosOutBits   = 16;
  localparam int unsigned InDataBits   = 24;
  localparam int unsigned InFieldBits  = 1 + TargetBits;
  localparam int unsigned OutDataBits  = 24;
  localparam int unsigned OutFieldBits = 4 + PosOutBits;

  typedef struct packed {
    logic scan_upward;
    logic clock_phase;
    logic auto_running;
    logic direction_level;
  } ctrl_t;

  typedef struct packed {
    logic                  scan_active;
    logic                  moving;
    logic [PosOutBits-1:0] position;
    logic                  direction_cw;
    logic                  step_clock;
  } result_t;

endpackage : sdpsc_pkg
`default_nettype wire

@@ rtl/core/sdpsc_step_logic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdpsc_step_logic
// Next-state and result logic for one half-period tick: target load, mode
// change, then one clock action for goto or triangle scan.
// ----------------------------------------------------------------------------
module sdpsc_step_logic
  import sdpsc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     auto_enable_i,
  input  logic [TargetBits-1:0]    target_position_i,
  input  logic                     target_write_i,
  input  logic [LimitBits-1:0]     upper_limit_i,
  input  logic [POSITION_BITS-1:0] position_i,
  input  logic [POSITION_BITS-1:0] goto_target_i,
  input  logic [POSITION_BITS-1:0] scan_limit_i,
  input  ctrl_t                    ctrl_i,
  output logic [POSITION_BITS-1:0] position_o,
  output logic [POSITION_BITS-1:0] goto_target_o,
  output logic [POSITION_BITS-1:0] scan_limit_o,
  output ctrl_t                    ctrl_o,
  output result_t                  result_o
);

  localparam int unsigned CmpBits = (POSITION_BITS > LimitBits) ? POSITION_BITS : LimitBits;

  logic [POSITION_BITS-1:0] tgt;
  logic [POSITION_BITS-1:0] goto_w;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] pos_dec;
  logic                     enter;
  logic                     leave;
  logic                     accepted;

  assign tgt     = POSITION_BITS'(target_position_i);
  assign goto_w  = target_write_i ? tgt : goto_target_i;
  assign enter   = auto_enable_i && !ctrl_i.auto_running && (goto_w != '0);
  assign leave   = !auto_enable_i && ctrl_i.auto_running;
  assign pos_inc = position_i + POSITION_BITS'(1);
  assign pos_dec = position_i - POSITION_BITS'(1);

  always_comb begin
    ctrl_o        = ctrl_i;
    position_o    = position_i;
    scan_limit_o  = enter ? goto_w : scan_limit_i;
    goto_target_o = leave ? scan_limit_i : goto_w;
    ctrl_o.auto_running = auto_enable_i && (ctrl_i.auto_running || enter);

    if (ctrl_o.auto_running) begin
      if (!ctrl_i.clock_phase) begin
        ctrl_o.clock_phase = 1'b1;
      end else begin
        ctrl_o.clock_phase = 1'b0;
        if (ctrl_i.scan_upward) begin
          ctrl_o.direction_level = 1'b1;
          if (position_i < scan_limit_o) begin
            position_o = pos_inc;
          end else begin
            ctrl_o.scan_upward = 1'b0;
          end
        end else begin
          ctrl_o.direction_level = 1'b0;
          if (position_i != '0) begin
            position_o = pos_dec;
          end else begin
            ctrl_o.scan_upward = 1'b1;
          end
        end
      end
    end else begin
      if (ctrl_i.clock_phase) begin
        ctrl_o.clock_phase = 1'b0;
        position_o = ctrl_i.direction_level ? pos_inc : pos_dec;
      end else if ((CmpBits'(goto_target_o) <= CmpBits'(upper_limit_i)) &&
                   (goto_target_o != position_i)) begin
        ctrl_o.direction_level = goto_target_o > position_i;
        ctrl_o.clock_phase     = 1'b1;
      end
    end
  end

  assign accepted = CmpBits'(goto_target_o) <= CmpBits'(upper_limit_i);

  always_comb begin
    result_o.step_clock   = ctrl_o.clock_phase;
    result_o.direction_cw = ctrl_o.direction_level;
    result_o.position     = PosOutBits'(position_o);
    result_o.moving       = ctrl_o.auto_running || ctrl_o.clock_phase ||
                            (accepted && (goto_target_o != position_o));
    result_o.scan_active  = ctrl_o.auto_running;
  end

endmodule : sdpsc_step_logic
`default_nettype wire

@@ rtl/core/step_dir_position_scan_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// step_dir_position_scan_controller
// Step/direction generator with absolute position, goto and triangle scan.
// ----------------------------------------------------------------------------
// Each input beat is one half-period tick. The block takes one tick per clock
// cycle unless the output stalls: a tick is held in an input register, and in
// the cycle it leaves that register the combinational step logic updates the
// position and mode state and loads the result register. Both sides stall
// independently; a full rate stream runs with no bubbles. The user must write
// upper_limit only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module step_dir_position_scan_controller
  import sdpsc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LimitBits-1:0]   cfg_wdata_i,   // upper_limit
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,  // auto_enable, target_position[16]
  input  logic                   s_axis_tuser,  // target_write
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata   // step_clock, direction_cw,
                                                // position[16], moving, scan_active
);

  logic                     in_valid_q;
  logic                     in_auto_q;
  logic [TargetBits-1:0]    in_target_q;
  logic                     in_write_q;
  logic                     out_valid_q;
  logic [OutFieldBits-1:0]  out_data_q;
  logic [LimitBits-1:0]     upper_limit_q;
  logic [POSITION_BITS-1:0] position_q, position_d;
  logic [POSITION_BITS-1:0] goto_target_q, goto_target_d;
  logic [POSITION_BITS-1:0] scan_limit_q, scan_limit_d;
  ctrl_t                    ctrl_q, ctrl_d;
  result_t                  result;
  logic                     advance;
  logic                     in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  sdpsc_step_logic #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .auto_enable_i    (in_auto_q),
    .target_position_i(in_target_q),
    .target_write_i   (in_write_q),
    .upper_limit_i    (upper_limit_q),
    .position_i       (position_q),
    .goto_target_i    (goto_target_q),
    .scan_limit_i     (scan_limit_q),
    .ctrl_i           (ctrl_q),
    .position_o       (position_d),
    .goto_target_o    (goto_target_d),
    .scan_limit_o     (scan_limit_d),
    .ctrl_o           (ctrl_d),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      upper_limit_q <= '1;
      position_q    <= '0;
      goto_target_q <= '0;
      scan_limit_q  <= '0;
      ctrl_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        upper_limit_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        position_q    <= position_d;
        goto_target_q <= goto_target_d;
        scan_limit_q  <= scan_limit_d;
        ctrl_q        <= ctrl_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold payload until the next beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_auto_q   <= s_axis_tdata[0];
      in_target_q <= s_axis_tdata[TargetBits:1];
      in_write_q  <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataBits - OutFieldBits){1'b0}}, out_data_q};

`ifndef SYNTH
  a_pos_moves_on_fall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (position_d != position_q)) |-> (ctrl_q.clock_phase && !ctrl_d.clock_phase))
    else $error("position moved outside a falling tick");

  a_scan_limit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.auto_running |-> (scan_limit_q != '0))
    else $error("scan running with zero limit");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room downstream");
`endif

endmodule : step_dir_position_scan_controller
`default_nettype wire
